// ----- rtl/rrps_pkg.sv -----
`timescale 1ns / 1ps
// rrps_pkg: shared types and constants for the round-robin process scheduler.
// Used by rrps_slot_table, rrps_sequencer and round_robin_process_scheduler_core.

package rrps_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SPAWN = 2'd1;
    localparam logic [1:0] ACT_TERM  = 2'd2;
    localparam logic [1:0] ACT_KILL  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [1:0] STATUS_BAD_SEG = 2'd2;

    localparam logic [15:0] STACK_RESET   = 16'hff00;
    // slot n lives at segment (n + SEG_BASE_PAGE) * 0x1000
    localparam logic [3:0]  SEG_BASE_PAGE = 4'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] running_segment;
        logic [15:0] saved_stack;
        logic        foreground;
        logic [2:0]  target_slot;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  chosen_slot;
        logic [15:0] next_segment;
        logic [15:0] next_stack;
        logic        switched;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SCAN_RUN,
        SCAN_FREE,
        SCAN_WAITER
    } scan_mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SAVE,
        OP_SELECT,
        OP_SPAWN,
        OP_DEACT,
        OP_WAKE,
        OP_CLRWAIT
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        logic    fg;
    } tbl_cmd_t;

endpackage

// ----- rtl/round_robin_process_scheduler_core.sv -----
`timescale 1ns / 1ps
// Round-robin process scheduler core: command word in, one result word out.
// Depends on rrps_pkg, rrps_slot_table and rrps_sequencer.

// One word at a time. After a word is taken the block walks the slot table one
// slot per cycle through a single compare unit. The word passes through START,
// a scan where needed, CLEAR after a terminate's scan, and DONE, which loads the
// result once the output register is free. in_ready returns in the same cycle
// that the result appears in that register, which is freed as soon as out_ready
// takes it. initial_stack is written through cfg_we and cfg_wdata; the user must
// do so only while idle, which the block does not enforce. It resets to 0xff00.

module round_robin_process_scheduler_core #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrps_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rrps_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [15:0]         init_stack_reg;
    logic                out_valid_reg, out_valid_next;
    rrps_pkg::out_word_t out_data_reg;

    logic                out_free;
    logic                load;
    rrps_pkg::out_word_t res;
    rrps_pkg::tbl_cmd_t  cmd;
    logic [SW-1:0]       cmd_idx;
    logic [15:0]         cmd_data;
    logic [SW-1:0]       probe_idx;
    logic                probe_active;
    logic                probe_wait_vld;
    logic [SW-1:0]       probe_wait_idx;
    logic [15:0]         probe_stack;
    logic [SW-1:0]       cur_slot;

    rrps_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_idx        (cmd_idx),
        .cmd_data       (cmd_data),
        .probe_idx      (probe_idx),
        .probe_active   (probe_active),
        .probe_wait_vld (probe_wait_vld),
        .probe_wait_idx (probe_wait_idx),
        .probe_stack    (probe_stack),
        .cur_slot       (cur_slot)
    );

    rrps_sequencer #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .init_stack     (init_stack_reg),
        .out_free       (out_free),
        .load           (load),
        .res            (res),
        .cmd            (cmd),
        .cmd_idx        (cmd_idx),
        .cmd_data       (cmd_data),
        .probe_idx      (probe_idx),
        .probe_active   (probe_active),
        .probe_wait_vld (probe_wait_vld),
        .probe_wait_idx (probe_wait_idx),
        .probe_stack    (probe_stack),
        .cur_slot       (cur_slot)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_stack_reg <= rrps_pkg::STACK_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                init_stack_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/rrps_slot_table.sv -----
`timescale 1ns / 1ps
// rrps_slot_table: per-slot active flag, wait link and saved stack, plus current slot.
// One update a cycle from the sequencer; one probe read port. Depends on rrps_pkg.

module rrps_slot_table #(
    parameter int SLOTS = 8,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rrps_pkg::tbl_cmd_t cmd,
    input  logic [SW-1:0]      cmd_idx,
    input  logic [15:0]        cmd_data,
    input  logic [SW-1:0]      probe_idx,
    output logic               probe_active,
    output logic               probe_wait_vld,
    output logic [SW-1:0]      probe_wait_idx,
    output logic [15:0]        probe_stack,
    output logic [SW-1:0]      cur_slot
);

    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] wvld_reg;
    logic [SW-1:0]    widx_reg [SLOTS];
    logic [15:0]      stack_reg [SLOTS];
    logic [SW-1:0]    cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            wvld_reg   <= '0;
            cur_reg    <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                stack_reg[i] <= rrps_pkg::STACK_RESET;
            end
        end
        else
        begin
            unique case (cmd.op)
                rrps_pkg::OP_SAVE:
                begin
                    stack_reg[cmd_idx] <= cmd_data;
                    cur_reg            <= cmd_idx;
                end
                rrps_pkg::OP_SELECT:
                begin
                    cur_reg <= cmd_idx;
                end
                rrps_pkg::OP_SPAWN:
                begin
                    stack_reg[cmd_idx]  <= cmd_data;
                    active_reg[cmd_idx] <= 1'b1;
                    if (cmd.fg)
                    begin
                        wvld_reg[cur_reg] <= 1'b1;
                    end
                end
                rrps_pkg::OP_DEACT:
                begin
                    active_reg[cmd_idx] <= 1'b0;
                end
                rrps_pkg::OP_WAKE:
                begin
                    wvld_reg[cmd_idx]   <= 1'b0;
                    active_reg[cmd_idx] <= 1'b1;
                end
                rrps_pkg::OP_CLRWAIT:
                begin
                    wvld_reg[cmd_idx] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // wait link index is only meaningful while its valid bit is set
    always_ff @(posedge clk)
    begin
        if (cmd.op == rrps_pkg::OP_SPAWN && cmd.fg)
        begin
            widx_reg[cur_reg] <= cmd_idx;
        end
    end

    assign probe_active   = active_reg[probe_idx];
    assign probe_wait_vld = wvld_reg[probe_idx];
    assign probe_wait_idx = widx_reg[probe_idx];
    assign probe_stack    = stack_reg[probe_idx];
    assign cur_slot       = cur_reg;

`ifndef SYNTHESIS
    ap_spawn_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == rrps_pkg::OP_SPAWN |=> active_reg[$past(cmd_idx)])
        else $error("spawned slot not active");

    ap_wake_runnable: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == rrps_pkg::OP_WAKE
        |=> active_reg[$past(cmd_idx)] && !wvld_reg[$past(cmd_idx)])
        else $error("woken slot not runnable");

    ap_deact_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == rrps_pkg::OP_DEACT |=> !active_reg[$past(cmd_idx)])
        else $error("deactivated slot still active");
`endif

endmodule

// ----- rtl/rrps_sequencer.sv -----
`timescale 1ns / 1ps
// rrps_sequencer: per-word control; walks the slot table one slot a cycle through a
// single probe compare and issues table updates. Depends on rrps_pkg.

module rrps_sequencer #(
    parameter int SLOTS = 8,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrps_pkg::in_word_t  in_data,
    input  logic [15:0]         init_stack,
    input  logic                out_free,
    output logic                load,
    output rrps_pkg::out_word_t res,
    output rrps_pkg::tbl_cmd_t  cmd,
    output logic [SW-1:0]       cmd_idx,
    output logic [15:0]         cmd_data,
    output logic [SW-1:0]       probe_idx,
    input  logic                probe_active,
    input  logic                probe_wait_vld,
    input  logic [SW-1:0]       probe_wait_idx,
    input  logic [15:0]         probe_stack,
    input  logic [SW-1:0]       cur_slot
);

    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    rrps_pkg::state_t     state_reg, state_next;
    rrps_pkg::scan_mode_t mode_reg, mode_next;
    rrps_pkg::in_word_t   item_reg, item_next;
    rrps_pkg::out_word_t  res_reg, res_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        cand_reg, cand_next;
    logic [SW-1:0]        key_reg, key_next;

    logic [3:0]    seg_page;
    logic [3:0]    page_off;
    logic          seg_ok;
    logic [SW+3:0] page_ext;
    logic [SW-1:0] tick_slot;
    logic [SW-1:0] tick_first;
    logic [SW+2:0] tgt_ext;
    logic          tgt_ok;
    logic [SW-1:0] tgt_slot;
    logic [SW+2:0] cur_ext;
    logic [SW+2:0] cand_ext;
    logic [SW+2:0] key_ext;
    logic [SW+3:0] seg_sum;
    logic [15:0]   cand_seg;
    logic [SW-1:0] cand_wrap;
    logic          last;
    logic          hit;
    logic          is_term;

    // decode of the held word
    assign seg_page   = item_reg.running_segment[15:12];
    assign page_off   = seg_page - rrps_pkg::SEG_BASE_PAGE;
    assign seg_ok     = (seg_page >= rrps_pkg::SEG_BASE_PAGE) && (32'(page_off) < SLOTS);
    assign page_ext   = (SW+4)'(page_off);
    assign tick_slot  = page_ext[SW-1:0];
    assign tick_first = (tick_slot == LAST) ? '0 : tick_slot + SW'(1);
    assign tgt_ext    = (SW+3)'(item_reg.target_slot);
    assign tgt_ok     = 32'(item_reg.target_slot) < SLOTS;
    assign tgt_slot   = tgt_ext[SW-1:0];
    assign is_term    = item_reg.action == rrps_pkg::ACT_TERM;

    assign cur_ext    = (SW+3)'(cur_slot);
    assign cand_ext   = (SW+3)'(cand_reg);
    assign key_ext    = (SW+3)'(key_reg);
    assign seg_sum    = (SW+4)'(cand_reg) + (SW+4)'(rrps_pkg::SEG_BASE_PAGE);
    assign cand_seg   = {seg_sum[3:0], 12'h000};
    assign cand_wrap  = (cand_reg == LAST) ? '0 : cand_reg + SW'(1);
    assign last       = cnt_reg == LAST;
    assign probe_idx  = cand_reg;

    // shared probe compare
    always_comb
    begin
        case (mode_reg)
            rrps_pkg::SCAN_RUN:    hit = probe_active && !probe_wait_vld;
            rrps_pkg::SCAN_FREE:   hit = !probe_active;
            rrps_pkg::SCAN_WAITER: hit = probe_wait_vld && (probe_wait_idx == key_reg);
            default:               hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrps_pkg::ST_START;
                end
            end
            rrps_pkg::ST_START:
            begin
                unique case (item_reg.action)
                    rrps_pkg::ACT_TICK:
                        state_next = seg_ok ? rrps_pkg::ST_SCAN : rrps_pkg::ST_DONE;
                    rrps_pkg::ACT_KILL:
                        state_next = tgt_ok ? rrps_pkg::ST_SCAN : rrps_pkg::ST_DONE;
                    rrps_pkg::ACT_SPAWN, rrps_pkg::ACT_TERM:
                        state_next = rrps_pkg::ST_SCAN;
                endcase
            end
            rrps_pkg::ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = (mode_reg == rrps_pkg::SCAN_WAITER && is_term)
                                 ? rrps_pkg::ST_CLEAR : rrps_pkg::ST_DONE;
                end
            end
            rrps_pkg::ST_CLEAR:
            begin
                state_next = rrps_pkg::ST_DONE;
            end
            rrps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rrps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == rrps_pkg::ST_IDLE;
        load      = 1'b0;
        cmd.op    = rrps_pkg::OP_NONE;
        cmd.fg    = item_reg.foreground;
        cmd_idx   = cand_reg;
        cmd_data  = item_reg.saved_stack;
        item_next = item_reg;
        res_next  = res_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        cand_next = cand_reg;
        key_next  = key_reg;
        unique case (state_reg)
            rrps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                end
            end
            rrps_pkg::ST_START:
            begin
                cnt_next  = '0;
                cand_next = '0;
                res_next  = '0;
                unique case (item_reg.action)
                    rrps_pkg::ACT_TICK:
                    begin
                        mode_next = rrps_pkg::SCAN_RUN;
                        cand_next = tick_first;
                        key_next  = tick_slot;
                        if (seg_ok)
                        begin
                            cmd.op  = rrps_pkg::OP_SAVE;
                            cmd_idx = tick_slot;
                        end
                        else
                        begin
                            res_next.status       = rrps_pkg::STATUS_BAD_SEG;
                            res_next.next_segment = item_reg.running_segment;
                            res_next.next_stack   = item_reg.saved_stack;
                        end
                    end
                    rrps_pkg::ACT_SPAWN:
                    begin
                        mode_next = rrps_pkg::SCAN_FREE;
                    end
                    rrps_pkg::ACT_TERM:
                    begin
                        mode_next            = rrps_pkg::SCAN_WAITER;
                        key_next             = cur_slot;
                        cmd.op               = rrps_pkg::OP_DEACT;
                        cmd_idx              = cur_slot;
                        res_next.chosen_slot = cur_ext[2:0];
                    end
                    rrps_pkg::ACT_KILL:
                    begin
                        mode_next            = rrps_pkg::SCAN_WAITER;
                        key_next             = tgt_slot;
                        res_next.chosen_slot = item_reg.target_slot;
                        if (tgt_ok)
                        begin
                            cmd.op  = rrps_pkg::OP_DEACT;
                            cmd_idx = tgt_slot;
                        end
                    end
                endcase
            end
            rrps_pkg::ST_SCAN:
            begin
                cnt_next  = cnt_reg + SW'(1);
                cand_next = cand_wrap;
                if (hit)
                begin
                    case (mode_reg)
                        rrps_pkg::SCAN_RUN:
                        begin
                            cmd.op                = rrps_pkg::OP_SELECT;
                            res_next.status       = rrps_pkg::STATUS_OK;
                            res_next.chosen_slot  = cand_ext[2:0];
                            res_next.next_segment = cand_seg;
                            res_next.next_stack   = probe_stack;
                            res_next.switched     = 1'b1;
                        end
                        rrps_pkg::SCAN_FREE:
                        begin
                            cmd.op                = rrps_pkg::OP_SPAWN;
                            cmd_data              = init_stack;
                            res_next.status       = rrps_pkg::STATUS_OK;
                            res_next.chosen_slot  = cand_ext[2:0];
                            res_next.next_segment = cand_seg;
                            res_next.next_stack   = init_stack;
                        end
                        rrps_pkg::SCAN_WAITER:
                        begin
                            cmd.op = rrps_pkg::OP_WAKE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (last)
                begin
                    case (mode_reg)
                        rrps_pkg::SCAN_RUN:
                        begin
                            // nothing runnable: resume the interrupted slot
                            res_next.chosen_slot  = key_ext[2:0];
                            res_next.next_segment = item_reg.running_segment;
                            res_next.next_stack   = item_reg.saved_stack;
                        end
                        rrps_pkg::SCAN_FREE:
                        begin
                            res_next.status = rrps_pkg::STATUS_NO_SLOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rrps_pkg::ST_CLEAR:
            begin
                cmd.op  = rrps_pkg::OP_CLRWAIT;
                cmd_idx = key_reg;
            end
            rrps_pkg::ST_DONE:
            begin
                load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        cand_reg <= cand_next;
        key_reg  <= key_next;
    end

`ifndef SYNTHESIS
    ap_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == rrps_pkg::ST_START)
        else $error("accepted word did not start");

    ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg == rrps_pkg::ST_IDLE && in_ready)
        else $error("not idle after result load");

    ap_select_current: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rrps_pkg::ST_SCAN && hit && mode_reg == rrps_pkg::SCAN_RUN
        |=> cur_slot == $past(cand_reg))
        else $error("selected slot not made current");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for round_robin_process_scheduler_core.
// Runs directed and random scheduler commands, predicts each result word and
// checks it. Depends on rrps_pkg and the scheduler RTL.

module tb_top;

    localparam int SLOTS = 8;
    localparam logic [3:0] WAIT_NONE = 4'hF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    rrps_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rrps_pkg::out_word_t out_data;
    logic                cfg_we = 1'b0;
    logic [15:0]         cfg_wdata = '0;

    // shadow of the slot table
    bit          slot_live [SLOTS];
    logic [3:0]  slot_wait [SLOTS];
    logic [15:0] slot_sp [SLOTS];
    int          cur_slot;
    logic [15:0] spawn_stack;

    rrps_pkg::in_word_t  pending_commands [$];
    rrps_pkg::out_word_t expected_results [$];
    int          words_total = 0;
    int          results_seen = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          in_took = 1'b0;
    int          in_idle_pct = 32;
    int          out_idle_pct = 32;
    bit          stall_req = 1'b0;
    bit          stall_taken = 1'b0;
    int          stall_left = 0;

    round_robin_process_scheduler_core #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void release_waiter(int s);
        bit done;
        done = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!done && slot_wait[i] == 4'(s))
            begin
                slot_wait[i] = WAIT_NONE;
                slot_live[i] = 1'b1;
                done = 1'b1;
            end
        end
    endfunction

    function automatic rrps_pkg::out_word_t schedule_next(rrps_pkg::in_word_t w);
        rrps_pkg::out_word_t res;
        int page;
        int s;
        int c;
        int free_idx;
        bit found;
        res = '0;
        found = 1'b0;
        case (w.action)
            rrps_pkg::ACT_TICK:
            begin
                page = int'(w.running_segment[15:12]);
                if (page < int'(rrps_pkg::SEG_BASE_PAGE)
                    || page - int'(rrps_pkg::SEG_BASE_PAGE) >= SLOTS)
                begin
                    res.status = rrps_pkg::STATUS_BAD_SEG;
                    res.next_segment = w.running_segment;
                    res.next_stack = w.saved_stack;
                end
                else
                begin
                    s = page - int'(rrps_pkg::SEG_BASE_PAGE);
                    cur_slot = s;
                    slot_sp[s] = w.saved_stack;
                    for (int i = 1; i <= SLOTS; i++)
                    begin
                        c = (s + i) % SLOTS;
                        if (!found && slot_live[c] && slot_wait[c] == WAIT_NONE)
                        begin
                            found = 1'b1;
                            cur_slot = c;
                            res.chosen_slot = 3'(c);
                            res.next_segment = {4'(c) + rrps_pkg::SEG_BASE_PAGE, 12'h000};
                            res.next_stack = slot_sp[c];
                            res.switched = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        res.chosen_slot = 3'(s);
                        res.next_segment = w.running_segment;
                        res.next_stack = w.saved_stack;
                    end
                end
            end
            rrps_pkg::ACT_SPAWN:
            begin
                free_idx = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!slot_live[i])
                        free_idx = i;
                end
                if (free_idx == SLOTS)
                    res.status = rrps_pkg::STATUS_NO_SLOT;
                else
                begin
                    slot_sp[free_idx] = spawn_stack;
                    if (w.foreground)
                        slot_wait[cur_slot] = 4'(free_idx);
                    slot_live[free_idx] = 1'b1;
                    res.chosen_slot = 3'(free_idx);
                    res.next_segment = {4'(free_idx) + rrps_pkg::SEG_BASE_PAGE, 12'h000};
                    res.next_stack = spawn_stack;
                end
            end
            rrps_pkg::ACT_TERM:
            begin
                c = cur_slot;
                slot_live[c] = 1'b0;
                release_waiter(c);
                slot_wait[c] = WAIT_NONE;
                res.chosen_slot = 3'(c);
            end
            default:
            begin
                res.chosen_slot = w.target_slot;
                slot_live[w.target_slot] = 1'b0;
                release_waiter(int'(w.target_slot));
            end
        endcase
        return res;
    endfunction

    function automatic rrps_pkg::in_word_t command_word(logic [1:0] act, logic [15:0] seg,
                                                        logic [15:0] sp, logic fg,
                                                        logic [2:0] tgt);
        rrps_pkg::in_word_t w;
        w.action = act;
        w.running_segment = seg;
        w.saved_stack = sp;
        w.foreground = fg;
        w.target_slot = tgt;
        return w;
    endfunction

    // mostly well-formed ticks and process events, some bad segments
    function automatic rrps_pkg::in_word_t random_command();
        rrps_pkg::in_word_t w;
        int pick;
        int page;
        w.running_segment = 16'($urandom);
        w.saved_stack = 16'($urandom);
        w.foreground = 1'($urandom);
        w.target_slot = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            w.action = rrps_pkg::ACT_TICK;
            w.running_segment[15:12] = 4'($urandom_range(9, 2));
        end
        else if (pick < 45)
        begin
            w.action = rrps_pkg::ACT_TICK;
            page = $urandom_range(7);
            w.running_segment[15:12] = 4'(page < 2 ? page : page + 8);
        end
        else if (pick < 75)
            w.action = rrps_pkg::ACT_SPAWN;
        else if (pick < 85)
            w.action = rrps_pkg::ACT_TERM;
        else
            w.action = rrps_pkg::ACT_KILL;
        return w;
    endfunction

    task automatic queue_command(rrps_pkg::in_word_t w);
        pending_commands.push_back(w);
        words_total++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_command(random_command());
    endtask

    task automatic drain();
        while (results_seen < words_total)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_initial_stack(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        spawn_stack = v;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (rst_n && pending_commands.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                in_data <= pending_commands.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (stall_req && !stall_taken)
        begin
            stall_taken = 1'b1;
            stall_left = 300;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        rrps_pkg::out_word_t want;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: %0h", out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0h, got %0h", want.status, out_data.status);
                        error_count++;
                    end
                    if (out_data.chosen_slot !== want.chosen_slot)
                    begin
                        $error("chosen_slot: expected %0h, got %0h",
                               want.chosen_slot, out_data.chosen_slot);
                        error_count++;
                    end
                    if (out_data.next_segment !== want.next_segment)
                    begin
                        $error("next_segment: expected %0h, got %0h",
                               want.next_segment, out_data.next_segment);
                        error_count++;
                    end
                    if (out_data.next_stack !== want.next_stack)
                    begin
                        $error("next_stack: expected %0h, got %0h",
                               want.next_stack, out_data.next_stack);
                        error_count++;
                    end
                    if (out_data.switched !== want.switched)
                    begin
                        $error("switched: expected %0h, got %0h",
                               want.switched, out_data.switched);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                in_took = 1'b1;
                expected_results.push_back(schedule_next(in_data));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_wait[i] = WAIT_NONE;
            slot_sp[i] = rrps_pkg::STACK_RESET;
        end
        cur_slot = 0;
        spawn_stack = rrps_pkg::STACK_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: self wait, idle tick, bad segments, full table, kills
        queue_command(command_word(rrps_pkg::ACT_SPAWN, 16'h0000, 16'h0000, 1'b1, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'h2000, 16'h1234, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'h0000, 16'h0000, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'h1FFF, 16'hFFFF, 1'b1, 3'd7));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'hA000, 16'h5555, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'hFFFF, 16'h0000, 1'b1, 3'd7));
        for (int i = 0; i < 7; i++)
            queue_command(command_word(rrps_pkg::ACT_SPAWN, 16'hFFFF, 16'hFFFF, 1'b0, 3'd7));
        queue_command(command_word(rrps_pkg::ACT_SPAWN, 16'h0000, 16'h0000, 1'b1, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'h9FFF, 16'hFFFF, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_KILL, 16'h0000, 16'h0000, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_KILL, 16'h0000, 16'h0000, 1'b0, 3'd3));
        queue_command(command_word(rrps_pkg::ACT_SPAWN, 16'h0000, 16'h0000, 1'b1, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TERM, 16'h0000, 16'h0000, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_KILL, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7));
        queue_command(command_word(rrps_pkg::ACT_TICK, 16'h2000, 16'h0000, 1'b0, 3'd0));
        queue_command(command_word(rrps_pkg::ACT_TERM, 16'hFFFF, 16'hFFFF, 1'b1, 3'd7));
        drain();

        write_initial_stack(16'h0000);
        in_idle_pct = 0;
        out_idle_pct = 0;
        queue_random(200);
        drain();

        write_initial_stack(16'hFFFF);
        in_idle_pct = 32;
        out_idle_pct = 32;
        stall_req = 1'b1;
        queue_random(200);
        drain();

        write_initial_stack(16'($urandom_range(16'hFFFE, 1)));
        queue_random(150);
        drain();

        write_initial_stack(rrps_pkg::STACK_RESET);
        queue_random(50);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rrps_pkg.sv
rtl/rrps_slot_table.sv
rtl/rrps_sequencer.sv
rtl/round_robin_process_scheduler_core.sv
tb/tb_top.sv
